[rtl/lpe_pkg.sv]
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared constants, widths and status codes for the Legendre evaluator.
// ----------------------------------------------------------------------------
package lpe_pkg;

   localparam int MAX_DEGREE = 64;
   localparam int FRAC_BITS  = 30;
   localparam int DEG_W      = 7;
   localparam int PT_W       = 32;
   localparam int SLOPE_W    = 48;
   localparam int STAT_W     = 2;

   // x*P product, |p| <= 2^60
   localparam int PROD_W  = 62;
   // recurrence numerator, |num| < 2^38
   localparam int NUM_W   = 39;
   // x*P_n - P_{n-1}*1.0, |d| <= 2^61
   localparam int DIFF_W  = 63;
   localparam int MAG_W   = 62;
   // n*|diff| << FRAC_BITS
   localparam int SNUM_W  = DEG_W + MAG_W + FRAC_BITS;
   localparam int DEN_W   = 2 * FRAC_BITS + 1;
   localparam int CNT_W   = 7;

   localparam logic signed [PT_W-1:0] ONE_FX = PT_W'(1) << FRAC_BITS;
   localparam logic [DEN_W-1:0] ONE_SQ = DEN_W'(1) << (2 * FRAC_BITS);
   localparam logic [SLOPE_W-1:0] SLOPE_POS_LIM = {1'b0, {(SLOPE_W-1){1'b1}}};
   localparam logic [SLOPE_W-1:0] SLOPE_NEG_LIM = {1'b1, {(SLOPE_W-1){1'b0}}};

   typedef logic [STAT_W-1:0] status_type;

   localparam status_type STAT_OK       = 2'd0;
   localparam status_type STAT_ENDPOINT = 2'd1;
   localparam status_type STAT_SAT      = 2'd2;

endpackage

[rtl/legendre_poly_eval.sv]
// ----------------------------------------------------------------------------
// legendre_poly_eval
// Fixed-point Legendre polynomial P_n(x) and slope, Bonnet recurrence.
// ----------------------------------------------------------------------------
// Usage:
//   csr_ channel writes the degree n (0..64, larger reads as 64); write it
//   only while the block is idle. csr_ready is always high.
//   req_ channel carries one point x (Q1.30, clamped to [-1,1]) per word.
//   rsp_ channel returns one word per point: P_n(x) in Q1.30, P'_n(x) in
//   Q17.30 and a status (ok, endpoint, saturated).
// Sequencing (one point in flight at a time):
//   degree 0 or 1 : result set directly, no recurrence
//   degree n >= 2 : n-1 recurrence steps, then the slope division
//   Each recurrence step is one 32x32 multiply plus a radix-2 divider by
//   (i+1); the slope uses a wider radix-2 divider.
// Reset clears the degree to 0, returns to idle and empties the rsp_ register.
// A finished word sits in the rsp_ register while rsp_stall is high; the
// next point is accepted meanwhile and its result waits in a staging
// register until the output register frees up.
// ----------------------------------------------------------------------------
module legendre_poly_eval
   import lpe_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [DEG_W-1:0]          csr_degree,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [PT_W-1:0]    req_point,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [PT_W-1:0]    rsp_poly_value,
   output logic signed [SLOPE_W-1:0] rsp_poly_slope,
   output logic [STAT_W-1:0]         rsp_slope_status
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL  = 4'd1;
   localparam logic [3:0] S_RND  = 4'd2;
   localparam logic [3:0] S_LOAD = 4'd3;
   localparam logic [3:0] S_DIV  = 4'd4;
   localparam logic [3:0] S_NEXT = 4'd5;
   localparam logic [3:0] S_SMUL = 4'd6;
   localparam logic [3:0] S_SSQ  = 4'd7;
   localparam logic [3:0] S_SSET = 4'd8;
   localparam logic [3:0] S_SDIV = 4'd9;
   localparam logic [3:0] S_SRND = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);
   localparam logic [CNT_W-1:0] SDIV_LAST = CNT_W'(SNUM_W - 1);

   logic [3:0]                state_ff, state_in;
   logic [DEG_W-1:0]          degree_ff, degree_in;
   logic signed [PT_W-1:0]    x_ff, x_in, prev_ff, prev_in, cur_ff, cur_in, t_ff, t_in;
   logic [DEG_W-1:0]          n_ff, n_in, i_ff, i_in, d_ff, d_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [DEN_W-1:0]          sq_ff, sq_in, den_ff, den_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic                      dsgn_ff, dsgn_in, neg_ff, neg_in;
   logic [NUM_W-1:0]          sdq_ff, sdq_in;
   logic [DEG_W-1:0]          srem_ff, srem_in;
   logic [SNUM_W-1:0]         wdq_ff, wdq_in;
   logic [DEN_W-1:0]          wrem_ff, wrem_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [PT_W-1:0]    res_value_ff, res_value_in;
   logic signed [SLOPE_W-1:0] res_slope_ff, res_slope_in;
   status_type                res_stat_ff, res_stat_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [PT_W-1:0]    rsp_value_ff, rsp_value_in;
   logic signed [SLOPE_W-1:0] rsp_slope_ff, rsp_slope_in;
   status_type                rsp_stat_ff, rsp_stat_in;

   logic                      req_take, rsp_free;
   logic signed [PT_W-1:0]    xc;
   logic [DEG_W-1:0]          nn;
   logic signed [63:0]        mul_p;
   logic [PROD_W-1:0]         pm;
   logic [PT_W-1:0]           tm;
   logic signed [NUM_W-1:0]   num;
   logic [NUM_W-1:0]          num_mag;
   logic [DEG_W:0]            rsh;
   logic                      ge;
   logic [PT_W-1:0]           qc;
   logic [MAG_W-1:0]          dmag;
   logic [DEN_W:0]            wsh;
   logic                      wge;
   logic [SNUM_W:0]           qr;
   logic [SLOPE_W-1:0]        qlim;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_poly_value   = rsp_value_ff;
   assign rsp_poly_slope   = rsp_slope_ff;
   assign rsp_slope_status = rsp_stat_ff;

   always_comb begin
      xc = req_point;
      if (req_point > ONE_FX) begin
         xc = ONE_FX;
      end else if (req_point < -ONE_FX) begin
         xc = -ONE_FX;
      end
      nn = (degree_ff > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_ff;

      mul_p = (state_ff == S_SSQ) ? x_ff * x_ff : x_ff * cur_ff;

      // round half away from zero
      pm = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      tm = PT_W'((pm + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);

      num = NUM_W'(signed'({1'b0, i_ff, 1'b1})) * NUM_W'(t_ff)
          - NUM_W'(signed'({1'b0, i_ff})) * NUM_W'(prev_ff);
      num_mag = (num < 0) ? NUM_W'(-num) : NUM_W'(num);

      rsh = {srem_ff, sdq_ff[NUM_W-1]};
      ge  = (rsh >= {1'b0, d_ff});

      qc = (sdq_ff > NUM_W'(ONE_FX)) ? ONE_FX : sdq_ff[PT_W-1:0];

      dmag = (diff_ff < 0) ? MAG_W'(-diff_ff) : MAG_W'(diff_ff);

      wsh = {wrem_ff, wdq_ff[SNUM_W-1]};
      wge = (wsh >= {1'b0, den_ff});

      qr = {1'b0, wdq_ff} + ((wrem_ff >= den_ff - wrem_ff) ? (SNUM_W+1)'(1) : '0);
      qlim = neg_ff ? SLOPE_NEG_LIM : SLOPE_POS_LIM;
   end

   always_comb begin
      state_in     = state_ff;
      degree_in    = degree_ff;
      x_in         = x_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      sq_in        = sq_ff;
      den_in       = den_ff;
      diff_in      = diff_ff;
      dsgn_in      = dsgn_ff;
      neg_in       = neg_ff;
      sdq_in       = sdq_ff;
      srem_in      = srem_ff;
      wdq_in       = wdq_ff;
      wrem_in      = wrem_ff;
      cnt_in       = cnt_ff;
      res_value_in = res_value_ff;
      res_slope_in = res_slope_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_slope_in = rsp_slope_ff;
      rsp_stat_in  = rsp_stat_ff;

      if (csr_valid && csr_ready) begin
         degree_in = csr_degree;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               x_in    = xc;
               n_in    = nn;
               prev_in = ONE_FX;
               cur_in  = xc;
               i_in    = DEG_W'(1);
               res_stat_in = STAT_OK;
               if (nn == '0) begin
                  res_value_in = ONE_FX;
                  res_slope_in = '0;
                  state_in     = S_OUT;
               end else if (nn == DEG_W'(1)) begin
                  res_value_in = xc;
                  res_slope_in = SLOPE_W'(ONE_FX);
                  state_in     = S_OUT;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(mul_p);
            state_in = S_RND;
         end
         S_RND: begin
            t_in     = prod_ff[PROD_W-1] ? -signed'(tm) : signed'(tm);
            state_in = S_LOAD;
         end
         S_LOAD: begin
            d_in     = i_ff + DEG_W'(1);
            sdq_in   = num_mag + NUM_W'((i_ff + DEG_W'(1)) >> 1);
            srem_in  = '0;
            dsgn_in  = (num < 0);
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            srem_in = ge ? DEG_W'(rsh - {1'b0, d_ff}) : DEG_W'(rsh);
            sdq_in  = {sdq_ff[NUM_W-2:0], ge};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            prev_in = cur_ff;
            cur_in  = dsgn_ff ? -signed'(qc) : signed'(qc);
            i_in    = i_ff + DEG_W'(1);
            state_in = ((i_ff + DEG_W'(1)) < n_ff) ? S_MUL : S_SMUL;
         end
         S_SMUL: begin
            prod_in  = PROD_W'(mul_p);
            state_in = S_SSQ;
         end
         S_SSQ: begin
            sq_in    = DEN_W'(mul_p);
            diff_in  = DIFF_W'(prod_ff) - (DIFF_W'(prev_ff) <<< FRAC_BITS);
            state_in = S_SSET;
         end
         S_SSET: begin
            res_value_in = cur_ff;
            if (sq_ff == ONE_SQ) begin
               res_slope_in = '0;
               res_stat_in  = STAT_ENDPOINT;
               state_in     = S_OUT;
            end else begin
               den_in   = ONE_SQ - sq_ff;
               neg_in   = (diff_ff > 0);
               wdq_in   = SNUM_W'(SNUM_W'(dmag) * SNUM_W'(n_ff)) << FRAC_BITS;
               wrem_in  = '0;
               cnt_in   = '0;
               state_in = S_SDIV;
            end
         end
         S_SDIV: begin
            wrem_in = wge ? DEN_W'(wsh - {1'b0, den_ff}) : DEN_W'(wsh);
            wdq_in  = {wdq_ff[SNUM_W-2:0], wge};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == SDIV_LAST) begin
               state_in = S_SRND;
            end
         end
         S_SRND: begin
            if (qr > (SNUM_W+1)'(qlim)) begin
               res_slope_in = neg_ff ? signed'(SLOPE_W'(-qlim)) : signed'(qlim);
               res_stat_in  = STAT_SAT;
            end else begin
               res_slope_in = neg_ff ? -signed'(SLOPE_W'(qr)) : signed'(SLOPE_W'(qr));
               res_stat_in  = STAT_OK;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_slope_in = res_slope_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         degree_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         degree_ff    <= degree_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      n_ff         <= n_in;
      i_ff         <= i_in;
      d_ff         <= d_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      t_ff         <= t_in;
      prod_ff      <= prod_in;
      sq_ff        <= sq_in;
      den_ff       <= den_in;
      diff_ff      <= diff_in;
      dsgn_ff      <= dsgn_in;
      neg_ff       <= neg_in;
      sdq_ff       <= sdq_in;
      srem_ff      <= srem_in;
      wdq_ff       <= wdq_in;
      wrem_ff      <= wrem_in;
      cnt_ff       <= cnt_in;
      res_value_ff <= res_value_in;
      res_slope_ff <= res_slope_in;
      res_stat_ff  <= res_stat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_slope_ff <= rsp_slope_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   // endpoint words always carry a zero slope
   a_endpoint_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_stat_ff == STAT_ENDPOINT) |-> (rsp_slope_ff == '0))
      else $error("endpoint word with nonzero slope");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff <= ONE_FX) && (rsp_value_ff >= -ONE_FX))
      else $error("value outside [-1,1]");

   a_div_by_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (d_ff == i_ff + DEG_W'(1)) && (i_ff < n_ff))
      else $error("step divisor out of sync with step count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE))
      else $error("accepted point did not start work");

endmodule
